### sv/earliest_free_unit_scheduler_defines.svh
// ----------------------------------------------------------------------------
// earliest_free_unit_scheduler_defines
// Assertion macros used by the scheduler controller; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_UNIT_SCHEDULER_DEFINES_SVH
`define EARLIEST_FREE_UNIT_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define EFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// next-cycle implication
`define EFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`else

`define EFS_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define EFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/efus_pkg.sv
// ----------------------------------------------------------------------------
// efus_pkg
// Widths, register indexes and shared types of the earliest-free unit scheduler.
// ----------------------------------------------------------------------------
package efus_pkg;

  // number of cipher units
  localparam int UNITS = 4;

  // field widths
  localparam int TICK_W     = 48;
  localparam int SIZE_W     = 13;
  localparam int BB_W       = 7;
  localparam int LAT_W      = 8;
  localparam int II_W       = 8;
  localparam int TPC_W      = 16;
  localparam int UNIT_OUT_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_LATENCY     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_LATENCY     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENC_INTERVAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEC_INTERVAL    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_CYCLE = 3'd5;

  // derived widths
  localparam int UNIT_W     = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int CALC_STEPS = (UNITS > SIZE_W) ? UNITS : SIZE_W;
  localparam int STEP_W     = $clog2(CALC_STEPS);
  localparam int PROD1_W    = SIZE_W + II_W;
  localparam int BUSY_W     = PROD1_W + TPC_W;
  localparam int LATT_W     = LAT_W + TPC_W;
  localparam int DONE_W     = BUSY_W + 1;

  // configuration registers
  typedef struct packed {
    logic [BB_W-1:0]  block_bytes;
    logic [LAT_W-1:0] enc_latency;
    logic [LAT_W-1:0] dec_latency;
    logic [II_W-1:0]  enc_interval;
    logic [II_W-1:0]  dec_interval;
    logic [TPC_W-1:0] ticks_per_cycle;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic calc;
    logic mul1;
    logic mul2;
    logic add1;
    logic add2;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic calc_done;
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CALC = 6'b000010,
    S_MUL1 = 6'b000100,
    S_MUL2 = 6'b001000,
    S_ADD1 = 6'b010000,
    S_ADD2 = 6'b100000
  } state_t;

endpackage

### sv/efus_cfg.sv
// ----------------------------------------------------------------------------
// efus_cfg
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module efus_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [efus_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efus_pkg::CFG_DATA_W-1:0] cfg_data,
  output efus_pkg::cfg_t                 cfg
);
  import efus_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_BYTES:     cfg_nxt.block_bytes     = cfg_data[BB_W-1:0];
        CFG_ENC_LATENCY:     cfg_nxt.enc_latency     = cfg_data[LAT_W-1:0];
        CFG_DEC_LATENCY:     cfg_nxt.dec_latency     = cfg_data[LAT_W-1:0];
        CFG_ENC_INTERVAL:    cfg_nxt.enc_interval    = cfg_data[II_W-1:0];
        CFG_DEC_INTERVAL:    cfg_nxt.dec_interval    = cfg_data[II_W-1:0];
        CFG_TICKS_PER_CYCLE: cfg_nxt.ticks_per_cycle = cfg_data[TPC_W-1:0];
        default: ;
      endcase
    end
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_bytes     <= BB_W'(16);
      cfg_r.enc_latency     <= LAT_W'(10);
      cfg_r.dec_latency     <= LAT_W'(10);
      cfg_r.enc_interval    <= II_W'(1);
      cfg_r.dec_interval    <= II_W'(1);
      cfg_r.ticks_per_cycle <= TPC_W'(1000);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/efus_datapath.sv
// ----------------------------------------------------------------------------
// efus_datapath
// Unit ready times, min scan, block divider, multiplies and saturating adds.
// ----------------------------------------------------------------------------
module efus_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  efus_pkg::cfg_t                  cfg,
  input  efus_pkg::cmd_t                  cmd,
  output efus_pkg::status_t               status,
  input  logic                            in_req_type,
  input  logic [efus_pkg::TICK_W-1:0]     in_now_tick,
  input  logic [efus_pkg::SIZE_W-1:0]     in_packet_size,
  output logic [efus_pkg::TICK_W-1:0]     out_done_tick,
  output logic [efus_pkg::UNIT_OUT_W-1:0] out_unit_chosen
);
  import efus_pkg::*;

  localparam int SUM_W = TICK_W + 1;

  // saturating tick add
  function automatic logic [TICK_W-1:0] sat_add(input logic [TICK_W-1:0] a,
                                                input logic [DONE_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + SUM_W'(b);
    return s[TICK_W] ? {TICK_W{1'b1}} : s[TICK_W-1:0];
  endfunction

  // request registers
  logic [TICK_W-1:0]  now_r;
  logic [LAT_W-1:0]   lat_r;
  logic [II_W-1:0]    ii_r;
  logic [STEP_W-1:0]  step_r;

  // divider
  logic [SIZE_W-1:0]  quo_r;
  logic [BB_W-1:0]    rem_r;
  logic [BB_W-1:0]    bb_eff;
  logic [BB_W:0]      rem_try;
  logic [BB_W:0]      rem_sub;
  logic               div_take;
  logic [SIZE_W-1:0]  blocks_m1;

  // scan
  logic [TICK_W-1:0]  rt_r [UNITS];
  logic [TICK_W-1:0]  rt_rd;
  logic [TICK_W-1:0]  best_r;
  logic [UNIT_W-1:0]  sel_r;
  logic               scan_take;

  // arithmetic pipeline
  logic [PROD1_W-1:0] prod1_r;
  logic [LATT_W-1:0]  latt_r;
  logic [TICK_W-1:0]  start_r;
  logic [BUSY_W-1:0]  busy_r;
  logic [DONE_W-1:0]  dtk_r;

  // results
  logic [TICK_W-1:0]     done_r;
  logic [UNIT_OUT_W-1:0] unit_r;

  // block size of zero counts as one
  assign bb_eff = (cfg.block_bytes == '0) ? BB_W'(1) : cfg.block_bytes;

  // restoring divide step, one quotient bit per cycle
  assign rem_try  = {rem_r, quo_r[SIZE_W-1]};
  assign rem_sub  = rem_try - {1'b0, bb_eff};
  assign div_take = (rem_try >= {1'b0, bb_eff});

  // min scan step, ties keep the lower index
  assign rt_rd     = rt_r[step_r[UNIT_W-1:0]];
  assign scan_take = (step_r < STEP_W'(UNITS)) &&
                     ((step_r == '0) || (rt_rd < best_r));

  // blocks minus one, a short packet counts as one block
  assign blocks_m1 = (quo_r == '0) ? '0 : quo_r - SIZE_W'(1);

  assign status.calc_done = (step_r == STEP_W'(CALC_STEPS - 1));

  // request capture and divide/scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_now_tick;
      lat_r  <= in_req_type ? cfg.dec_latency : cfg.enc_latency;
      ii_r   <= in_req_type ? cfg.dec_interval : cfg.enc_interval;
      quo_r  <= in_packet_size;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.calc) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r < STEP_W'(SIZE_W)) begin
        quo_r <= {quo_r[SIZE_W-2:0], div_take};
        rem_r <= div_take ? rem_sub[BB_W-1:0] : rem_try[BB_W-1:0];
      end
      if (scan_take) begin
        best_r <= rt_rd;
        sel_r  <= step_r[UNIT_W-1:0];
      end
    end
  end

  // multiply and add stages
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_r <= PROD1_W'(blocks_m1) * PROD1_W'(ii_r);
      latt_r  <= LATT_W'(lat_r) * LATT_W'(cfg.ticks_per_cycle);
      start_r <= (now_r > best_r) ? now_r : best_r;
    end
    if (cmd.mul2) begin
      busy_r <= BUSY_W'(prod1_r) * BUSY_W'(cfg.ticks_per_cycle);
    end
    if (cmd.add1) begin
      dtk_r <= DONE_W'(busy_r) + DONE_W'(latt_r);
    end
    if (cmd.add2) begin
      done_r <= sat_add(start_r, dtk_r);
      unit_r <= UNIT_OUT_W'(sel_r);
    end
  end

  // unit ready times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < UNITS; i++) begin
        rt_r[i] <= '0;
      end
    end else if (cmd.add1) begin
      rt_r[sel_r] <= sat_add(start_r, DONE_W'(busy_r));
    end
  end

  assign out_done_tick   = done_r;
  assign out_unit_chosen = unit_r;

endmodule

### sv/efus_ctrl.sv
// ----------------------------------------------------------------------------
// efus_ctrl
// Sequencer for one request at a time and the result valid flag.
// ----------------------------------------------------------------------------
`include "earliest_free_unit_scheduler_defines.svh"

module efus_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  efus_pkg::status_t   status,
  output efus_pkg::cmd_t      cmd
);
  import efus_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || out_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (status.calc_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_ADD1;
      end
      S_ADD1: begin
        cmd.add1  = 1'b1;
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        if (slot_free) begin
          cmd.add2  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.add2) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // an accepted request starts the divide/scan phase
  `EFS_ASSERT_NEXT(a_accept_calc, clk, rst_n, in_valid && in_ready, state_r == S_CALC)
  // a waiting result is never overwritten
  `EFS_ASSERT_NEXT(a_hold_add2, clk, rst_n, (state_r == S_ADD2) && out_valid_r && !out_ready, (state_r == S_ADD2) && out_valid_r)
  // scan and divide finish before the multiplies
  `EFS_ASSERT_NEXT(a_calc_mul, clk, rst_n, (state_r == S_CALC) && status.calc_done, state_r == S_MUL1)
  // a request is taken only when idle
  `EFS_ASSERT_IMPL(a_load_idle, clk, rst_n, cmd.load, state_r == S_IDLE)

endmodule

### sv/earliest_free_unit_scheduler.sv
// ----------------------------------------------------------------------------
// earliest_free_unit_scheduler
// Assigns each request to the cipher unit that frees up first and reports
// its completion tick.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_req_type, in_now_tick, in_packet_size
//   out      output     out_valid / out_ready out_done_tick, out_unit_chosen
//   cfg      input      cfg_we                cfg_index, cfg_data
//
// One request at a time: accept in IDLE, then the divide/scan phase in CALC
// (one quotient bit and one unit per cycle), then the MUL1, MUL2, ADD1 and ADD2
// states; with 4 units the 13-bit block divider, not the scan, sets the length of CALC.
// The next request is taken while the result register still waits; a held
// result stalls the sequencer only in its final state, ADD2.
// Synchronous active-low reset clears all unit ready times and loads the config defaults.
// ----------------------------------------------------------------------------
module earliest_free_unit_scheduler (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [efus_pkg::TICK_W-1:0]     in_now_tick,
  input  logic [efus_pkg::SIZE_W-1:0]     in_packet_size,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [efus_pkg::TICK_W-1:0]     out_done_tick,
  output logic [efus_pkg::UNIT_OUT_W-1:0] out_unit_chosen,
  input  logic                            cfg_we,
  input  logic [efus_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [efus_pkg::CFG_DATA_W-1:0] cfg_data
);
  import efus_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  efus_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  efus_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  efus_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .status          (status),
    .in_req_type     (in_req_type),
    .in_now_tick     (in_now_tick),
    .in_packet_size  (in_packet_size),
    .out_done_tick   (out_done_tick),
    .out_unit_chosen (out_unit_chosen)
  );

endmodule
